### hdl/tube_r2_command_tracker_assert.svh
// ----------------------------------------------------------------------------
// tube_r2_command_tracker_assert.svh
// assertion macros for the command tracker, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef TUBE_R2_COMMAND_TRACKER_ASSERT_SVH
`define TUBE_R2_COMMAND_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define TRK_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tracker assertion failed");
// next-cycle implication, checked out of reset
`define TRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tracker assertion failed");
`else
`define TRK_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/tube_trk_pkg.sv
// ----------------------------------------------------------------------------
// tube_trk_pkg
// register numbers, command codes and result word type of the command tracker
// ----------------------------------------------------------------------------
`default_nettype none

package tube_trk_pkg;

    // host interface register numbers that act
    localparam logic [2:0] REG_DATA = 3'd1;
    localparam logic [2:0] REG_CMD  = 3'd3;

    // command bytes seen in idle
    localparam logic [7:0] CMD_NOP      = 8'h00;
    localparam logic [7:0] CMD_STR      = 8'h02;
    localparam logic [7:0] CMD_SKIP2_A  = 8'h04;
    localparam logic [7:0] CMD_SKIP3    = 8'h06;
    localparam logic [7:0] CMD_WORD     = 8'h08;
    localparam logic [7:0] CMD_SKIP5    = 8'h0A;
    localparam logic [7:0] CMD_SKIP6    = 8'h0C;
    localparam logic [7:0] CMD_SKIP1    = 8'h0E;
    localparam logic [7:0] CMD_SKIP2_B  = 8'h10;
    localparam logic [7:0] CMD_FIND     = 8'h12;
    localparam logic [7:0] CMD_FILE     = 8'h14;
    localparam logic [7:0] CMD_SKIP14   = 8'h16;

    // parameter counts
    localparam logic [7:0] LEN_1     = 8'd1;
    localparam logic [7:0] LEN_2     = 8'd2;
    localparam logic [7:0] LEN_3     = 8'd3;
    localparam logic [7:0] LEN_5     = 8'd5;
    localparam logic [7:0] LEN_6     = 8'd6;
    localparam logic [7:0] LEN_14    = 8'd14;
    localparam logic [7:0] LEN_FILE  = 8'd16;

    // stream markers
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] BYTE_FF      = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] MODE_CMD     = 8'd22;
    localparam logic [7:0] MODE_ONE     = 8'd1;
    localparam logic [7:0] MODE_REMAP   = 8'd8;

    // one result word
    typedef struct packed {
        logic       display_valid;
        logic [7:0] display_byte;
        logic       mode_done;
        logic       cmd_error;
        logic       block_phase;
    } t_result;

endpackage

`default_nettype wire

### hdl/tube_r2_command_tracker.sv
// ----------------------------------------------------------------------------
// tube_r2_command_tracker
// parses host register writes, forwards display bytes, flags bad commands
// ----------------------------------------------------------------------------
// Each accepted register write gives exactly one result word. A write is
// captured in an input register, decoded by the parser from there, and its
// result lands in an output register. One write is taken every cycle while
// the result side keeps up; the input register holds one more write while a
// result waits to be taken. The user must write the configuration only while
// idle; the block itself does not enforce this.
`default_nettype none

`include "tube_r2_command_tracker_assert.svh"

module tube_r2_command_tracker
    import tube_trk_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    // write channel
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_reg_index,
    input  wire logic [7:0] i_write_byte,
    // result channel
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_display_valid,
    output logic [7:0]      o_display_byte,
    output logic            o_mode_done,
    output logic            o_cmd_error,
    output logic            o_block_phase
);

    typedef enum logic [3:0] {
        ST_IDLE        = 4'd0,
        ST_SKIP_N      = 4'd1,
        ST_SKIP_STR    = 4'd2,
        ST_WORD_CODE   = 4'd3,
        ST_WORD_INLEN  = 4'd4,
        ST_WORD_BLOCK  = 4'd5,
        ST_WORD_OUTLEN = 4'd6,
        ST_FF_MSB      = 4'd7,
        ST_FF_LSB      = 4'd8,
        ST_FF_CMD      = 4'd9,
        ST_FIND_A      = 4'd10,
        ST_FILE_BLOCK  = 4'd11,
        ST_FILE_STR    = 4'd12
    } t_parse_state;

    logic         r_display_enable;
    t_parse_state r_parse_state, n_parse_state;
    logic [7:0]   r_bytes_left, n_bytes_left;
    logic [7:0]   r_word_code, n_word_code;
    logic         r_mode_pending, n_mode_pending;

    logic         r_in_valid;
    logic [2:0]   r_in_reg;
    logic [7:0]   r_in_byte;
    logic         r_out_valid;
    t_result      r_result, n_result;

    logic         w_advance;
    logic         w_count_done;

    // input stage moves to the result stage when that one is free or drains
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_count_done = (r_bytes_left <= LEN_1);

    // parser and display stream decode
    always_comb begin
        n_parse_state  = r_parse_state;
        n_bytes_left   = r_bytes_left;
        n_word_code    = r_word_code;
        n_mode_pending = r_mode_pending;
        n_result       = '0;
        if (r_display_enable) begin
            if (r_in_reg == REG_CMD) begin
                unique case (r_parse_state)
                    ST_SKIP_N: begin
                        if (w_count_done) begin
                            n_bytes_left  = '0;
                            n_parse_state = ST_IDLE;
                        end else begin
                            n_bytes_left = r_bytes_left - LEN_1;
                        end
                    end
                    ST_SKIP_STR: begin
                        if (r_in_byte == BYTE_CR) n_parse_state = ST_IDLE;
                    end
                    ST_WORD_CODE: begin
                        n_word_code   = r_in_byte;
                        n_parse_state = ST_WORD_INLEN;
                    end
                    ST_WORD_INLEN: begin
                        n_bytes_left = r_in_byte;
                        if (r_word_code == BYTE_FF) n_parse_state = ST_FF_MSB;
                        else if (r_in_byte == BYTE_ZERO) n_parse_state = ST_WORD_OUTLEN;
                        else n_parse_state = ST_WORD_BLOCK;
                    end
                    ST_WORD_BLOCK: begin
                        if (w_count_done) begin
                            n_bytes_left  = '0;
                            n_parse_state = ST_WORD_OUTLEN;
                        end else begin
                            n_bytes_left = r_bytes_left - LEN_1;
                        end
                    end
                    ST_WORD_OUTLEN: n_parse_state = ST_IDLE;
                    ST_FF_MSB: begin
                        n_parse_state = (r_in_byte == BYTE_ZERO) ? ST_WORD_OUTLEN
                                                                 : ST_FF_LSB;
                    end
                    ST_FF_LSB: n_parse_state = ST_FF_CMD;
                    ST_FF_CMD: begin
                        if (r_in_byte == BYTE_FF) n_parse_state = ST_FF_MSB;
                    end
                    ST_FIND_A: n_parse_state = ST_SKIP_STR;
                    ST_FILE_BLOCK: begin
                        if (w_count_done) begin
                            n_bytes_left  = '0;
                            n_parse_state = ST_FILE_STR;
                        end else begin
                            n_bytes_left = r_bytes_left - LEN_1;
                        end
                    end
                    ST_FILE_STR: begin
                        if (r_in_byte == BYTE_CR) begin
                            n_bytes_left  = LEN_1;
                            n_parse_state = ST_SKIP_N;
                        end
                    end
                    default: begin
                        // idle: decode a command byte
                        n_parse_state = ST_IDLE;
                        unique case (r_in_byte)
                            CMD_NOP: n_parse_state = ST_IDLE;
                            CMD_STR: n_parse_state = ST_SKIP_STR;
                            CMD_SKIP2_A, CMD_SKIP2_B: begin
                                n_bytes_left  = LEN_2;
                                n_parse_state = ST_SKIP_N;
                            end
                            CMD_SKIP3: begin
                                n_bytes_left  = LEN_3;
                                n_parse_state = ST_SKIP_N;
                            end
                            CMD_WORD: n_parse_state = ST_WORD_CODE;
                            CMD_SKIP5: begin
                                n_bytes_left  = LEN_5;
                                n_parse_state = ST_SKIP_N;
                            end
                            CMD_SKIP6: begin
                                n_bytes_left  = LEN_6;
                                n_parse_state = ST_SKIP_N;
                            end
                            CMD_SKIP1: begin
                                n_bytes_left  = LEN_1;
                                n_parse_state = ST_SKIP_N;
                            end
                            CMD_FIND: n_parse_state = ST_FIND_A;
                            CMD_FILE: begin
                                n_bytes_left  = LEN_FILE;
                                n_parse_state = ST_FILE_BLOCK;
                            end
                            CMD_SKIP14: begin
                                n_bytes_left  = LEN_14;
                                n_parse_state = ST_SKIP_N;
                            end
                            default: n_result.cmd_error = 1'b1;
                        endcase
                    end
                endcase
            end else if (r_in_reg == REG_DATA && r_parse_state != ST_FF_CMD) begin
                // display byte, mode 1 after a mode change becomes mode 8
                n_result.display_valid = 1'b1;
                n_result.display_byte  = (r_mode_pending && r_in_byte == MODE_ONE)
                                         ? MODE_REMAP : r_in_byte;
                if (r_mode_pending) begin
                    n_mode_pending     = 1'b0;
                    n_result.mode_done = 1'b1;
                end else if (r_in_byte == MODE_CMD) begin
                    n_mode_pending = 1'b1;
                end
            end
        end
        n_result.block_phase = (n_parse_state == ST_FF_CMD);
    end

    // control and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable <= 1'b0;
            r_parse_state    <= ST_IDLE;
            r_bytes_left     <= '0;
            r_word_code      <= '0;
            r_mode_pending   <= 1'b0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_display_enable <= i_cfg_wr_data;
            if (o_ready) r_in_valid <= i_valid;
            if (w_advance) begin
                r_parse_state  <= n_parse_state;
                r_bytes_left   <= n_bytes_left;
                r_word_code    <= n_word_code;
                r_mode_pending <= n_mode_pending;
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_reg  <= i_reg_index;
            r_in_byte <= i_write_byte;
        end
        if (w_advance) r_result <= n_result;
    end

    assign o_valid         = r_out_valid;
    assign o_display_valid = r_result.display_valid;
    assign o_display_byte  = r_result.display_byte;
    assign o_mode_done     = r_result.mode_done;
    assign o_cmd_error     = r_result.cmd_error;
    assign o_block_phase   = r_result.block_phase;

    // checks
    `TRK_ASSERT_NOW(a_done_needs_byte, i_clk, i_rst_n, o_valid && o_mode_done, o_display_valid)
    `TRK_ASSERT_NOW(a_error_not_display, i_clk, i_rst_n, o_valid && o_cmd_error, !o_display_valid)
    `TRK_ASSERT_NOW(a_idle_byte_zero, i_clk, i_rst_n, o_valid && !o_display_valid, o_display_byte == BYTE_ZERO)
    `TRK_ASSERT_NEXT(a_pending_from_22, i_clk, i_rst_n, w_advance && !r_mode_pending && n_mode_pending, r_mode_pending && $past(r_in_byte) == MODE_CMD)

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// register write tracker: parser, display forwarding and word-transfer phase
// ----------------------------------------------------------------------------
// Drives host register writes into the tracker and predicts every result word
// with a cycle-free model of the command parser and the display byte filter.
// A short directed part hits unknown commands, the one-byte skip, the zero
// length word block, the 0xFF word-transfer phases and the mode remap. Random
// traffic then mixes well-formed command frames, display runs and noise under
// four idling mixes, with the display enable switched between phases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tube_trk_pkg::*;

    localparam int STALL_LIMIT = 2000;

    // parser states of the predictor
    typedef enum logic [3:0] {
        P_IDLE, P_SKIP_N, P_SKIP_STR, P_WORD_CODE, P_WORD_INLEN, P_WORD_BLOCK,
        P_WORD_OUTLEN, P_FF_MSB, P_FF_LSB, P_FF_CMD, P_FIND_A, P_FILE_BLOCK,
        P_FILE_STR
    } t_pred_state;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_reg_index;
    logic [7:0] i_write_byte;
    logic       o_valid;
    logic       i_ready;
    logic       o_display_valid;
    logic [7:0] o_display_byte;
    logic       o_mode_done;
    logic       o_cmd_error;
    logic       o_block_phase;

    // predictor state
    t_pred_state pst;
    logic [7:0]  left_cnt;
    logic [7:0]  code_q;
    logic        mode_pend;
    logic        show_en;
    t_result     expected_words[$];

    // stimulus and bookkeeping
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_driven  = 0;
    int words_checked = 0;
    int shown_bytes   = 0;
    int mode_changes  = 0;
    int cmd_errors    = 0;
    int phase_words   = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    tube_r2_command_tracker dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_reg_index     (i_reg_index),
        .i_write_byte    (i_write_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_display_valid (o_display_valid),
        .o_display_byte  (o_display_byte),
        .o_mode_done     (o_mode_done),
        .o_cmd_error     (o_cmd_error),
        .o_block_phase   (o_block_phase)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    // one register write through parser and display filter
    function automatic t_result track_write(input logic [2:0] reg_num,
                                            input logic [7:0] data);
        t_result    r;
        logic [7:0] b;
        r = '0;
        b = data;
        if (show_en) begin
            if (reg_num == REG_CMD) begin
                case (pst)
                    P_SKIP_N: begin
                        if (left_cnt <= LEN_1) begin
                            left_cnt = BYTE_ZERO;
                            pst = P_IDLE;
                        end else begin
                            left_cnt = left_cnt - 8'd1;
                        end
                    end
                    P_SKIP_STR: begin
                        if (data == BYTE_CR) pst = P_IDLE;
                    end
                    P_WORD_CODE: begin
                        code_q = data;
                        pst = P_WORD_INLEN;
                    end
                    P_WORD_INLEN: begin
                        left_cnt = data;
                        if (code_q == BYTE_FF) pst = P_FF_MSB;
                        else if (data == BYTE_ZERO) pst = P_WORD_OUTLEN;
                        else pst = P_WORD_BLOCK;
                    end
                    P_WORD_BLOCK: begin
                        if (left_cnt <= LEN_1) begin
                            left_cnt = BYTE_ZERO;
                            pst = P_WORD_OUTLEN;
                        end else begin
                            left_cnt = left_cnt - 8'd1;
                        end
                    end
                    P_WORD_OUTLEN: pst = P_IDLE;
                    P_FF_MSB: begin
                        if (data == BYTE_ZERO) pst = P_WORD_OUTLEN;
                        else pst = P_FF_LSB;
                    end
                    P_FF_LSB: pst = P_FF_CMD;
                    P_FF_CMD: begin
                        if (data == BYTE_FF) pst = P_FF_MSB;
                    end
                    P_FIND_A: pst = P_SKIP_STR;
                    P_FILE_BLOCK: begin
                        if (left_cnt <= LEN_1) begin
                            left_cnt = BYTE_ZERO;
                            pst = P_FILE_STR;
                        end else begin
                            left_cnt = left_cnt - 8'd1;
                        end
                    end
                    P_FILE_STR: begin
                        if (data == BYTE_CR) begin
                            left_cnt = LEN_1;
                            pst = P_SKIP_N;
                        end
                    end
                    default: begin
                        // idle: decode a command byte
                        pst = P_IDLE;
                        case (data)
                            CMD_NOP: begin end
                            CMD_STR: pst = P_SKIP_STR;
                            CMD_SKIP2_A, CMD_SKIP2_B: begin
                                left_cnt = LEN_2;
                                pst = P_SKIP_N;
                            end
                            CMD_SKIP3: begin
                                left_cnt = LEN_3;
                                pst = P_SKIP_N;
                            end
                            CMD_WORD: pst = P_WORD_CODE;
                            CMD_SKIP5: begin
                                left_cnt = LEN_5;
                                pst = P_SKIP_N;
                            end
                            CMD_SKIP6: begin
                                left_cnt = LEN_6;
                                pst = P_SKIP_N;
                            end
                            CMD_SKIP1: begin
                                left_cnt = LEN_1;
                                pst = P_SKIP_N;
                            end
                            CMD_FIND: pst = P_FIND_A;
                            CMD_FILE: begin
                                left_cnt = LEN_FILE;
                                pst = P_FILE_BLOCK;
                            end
                            CMD_SKIP14: begin
                                left_cnt = LEN_14;
                                pst = P_SKIP_N;
                            end
                            default: r.cmd_error = 1'b1;
                        endcase
                    end
                endcase
            end else if (reg_num == REG_DATA && pst != P_FF_CMD) begin
                // display byte, with the mode remap after a mode command
                if (mode_pend && b == MODE_ONE) b = MODE_REMAP;
                r.display_valid = 1'b1;
                r.display_byte = b;
                if (mode_pend) begin
                    mode_pend = 1'b0;
                    r.mode_done = 1'b1;
                end else if (b == MODE_CMD) begin
                    mode_pend = 1'b1;
                end
            end
        end
        r.block_phase = (pst == P_FF_CMD);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 20)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // predict on accepted writes, check accepted results, watch for a hang
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            pst = P_IDLE;
            left_cnt = BYTE_ZERO;
            code_q = BYTE_ZERO;
            mode_pend = 1'b0;
            show_en = 1'b0;
            idle_cycles = 0;
        end else begin
            if (i_cfg_wr_en) show_en = i_cfg_wr_data;
            if (i_valid && o_ready)
                expected_words.push_back(track_write(i_reg_index, i_write_byte));
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected", o_display_byte, BYTE_ZERO);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (want.display_valid) shown_bytes++;
                    if (want.mode_done) mode_changes++;
                    if (want.cmd_error) cmd_errors++;
                    if (want.block_phase) phase_words++;
                    if (o_display_valid !== want.display_valid)
                        report_mismatch("display_valid", 8'(o_display_valid),
                                        8'(want.display_valid));
                    if (o_display_byte !== want.display_byte)
                        report_mismatch("display_byte", o_display_byte, want.display_byte);
                    if (o_mode_done !== want.mode_done)
                        report_mismatch("mode_done", 8'(o_mode_done), 8'(want.mode_done));
                    if (o_cmd_error !== want.cmd_error)
                        report_mismatch("cmd_error", 8'(o_cmd_error), 8'(want.cmd_error));
                    if (o_block_phase !== want.block_phase)
                        report_mismatch("block_phase", 8'(o_block_phase),
                                        8'(want.block_phase));
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("no word moved for %0d cycles", STALL_LIMIT);
                $display("FAIL tube_r2_command_tracker");
                $finish;
            end
        end
    end

    // one register write, with random idle cycles ahead of it
    task automatic send_write(input logic [2:0] reg_num, input logic [7:0] data);
        while (int'($urandom_range(99)) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_reg_index <= reg_num;
        i_write_byte <= data;
        do @(posedge i_clk); while (!o_ready);
        items_driven++;
    endtask

    // hold off the write side until every result word has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_display_enable(input logic enable);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= enable;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_params(input int count);
        repeat (count) send_write(REG_CMD, 8'($urandom_range(255)));
    endtask

    // string of random bytes ended by a carriage return
    task automatic send_string();
        logic [7:0] b;
        repeat ($urandom_range(4)) begin
            do b = 8'($urandom); while (b == BYTE_CR);
            send_write(REG_CMD, b);
        end
        send_write(REG_CMD, BYTE_CR);
    endtask

    // word command, with a command phase loop when the code is 0xff
    task automatic send_word_frame();
        logic [7:0] code;
        logic [7:0] len;
        send_write(REG_CMD, CMD_WORD);
        code = ($urandom_range(2) == 0) ? BYTE_FF : 8'($urandom_range(255));
        send_write(REG_CMD, code);
        if (code == BYTE_FF) begin
            send_write(REG_CMD, 8'($urandom_range(255)));
            repeat ($urandom_range(2)) begin
                send_write(REG_CMD, 8'(1 + $urandom_range(254)));
                send_write(REG_CMD, 8'($urandom_range(255)));
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(1)) send_write(REG_DATA, 8'($urandom_range(255)));
                    else send_write(REG_CMD, 8'($urandom_range(254)));
                end
                send_write(REG_CMD, BYTE_FF);
            end
            send_write(REG_CMD, BYTE_ZERO);
        end else begin
            len = ($urandom_range(2) == 0) ? BYTE_ZERO : 8'($urandom_range(1, 8));
            send_write(REG_CMD, len);
            send_params(int'(len));
        end
        send_write(REG_CMD, 8'($urandom_range(255)));
    endtask

    // one well-formed command with random parameters, or an unknown command
    task automatic send_command_frame();
        logic [7:0] code;
        case ($urandom_range(12))
            0: send_write(REG_CMD, CMD_NOP);
            1: begin
                send_write(REG_CMD, CMD_STR);
                send_string();
            end
            2: begin
                send_write(REG_CMD, CMD_SKIP2_A);
                send_params(int'(LEN_2));
            end
            3: begin
                send_write(REG_CMD, CMD_SKIP3);
                send_params(int'(LEN_3));
            end
            4: send_word_frame();
            5: begin
                send_write(REG_CMD, CMD_SKIP5);
                send_params(int'(LEN_5));
            end
            6: begin
                send_write(REG_CMD, CMD_SKIP6);
                send_params(int'(LEN_6));
            end
            7: begin
                send_write(REG_CMD, CMD_SKIP1);
                send_params(int'(LEN_1));
            end
            8: begin
                send_write(REG_CMD, CMD_SKIP2_B);
                send_params(int'(LEN_2));
            end
            9: begin
                send_write(REG_CMD, CMD_FIND);
                send_params(int'(LEN_1));
                send_string();
            end
            10: begin
                send_write(REG_CMD, CMD_FILE);
                send_params(int'(LEN_FILE));
                send_string();
                send_params(int'(LEN_1));
            end
            11: begin
                send_write(REG_CMD, CMD_SKIP14);
                send_params(int'(LEN_14));
            end
            default: begin
                // known codes are the even bytes up to 0x16
                do code = 8'($urandom); while (!code[0] && code <= CMD_SKIP14);
                send_write(REG_CMD, code);
            end
        endcase
    endtask

    // display bytes, often a mode command and its argument
    task automatic send_display_run();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(3) == 0) begin
                send_write(REG_DATA, MODE_CMD);
                if ($urandom_range(1)) send_write(REG_DATA, MODE_ONE);
                else send_write(REG_DATA, 8'($urandom_range(255)));
            end else begin
                send_write(REG_DATA, 8'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // display enable low out of reset: nothing decoded or forwarded
    task automatic test_writes_while_disabled();
        send_write(REG_DATA, MODE_CMD);
        send_write(REG_CMD, CMD_WORD);
        send_write(REG_CMD, BYTE_FF);
        send_write(3'd7, BYTE_FF);
    endtask

    // unknown commands, one-byte skip and the registers that do nothing
    task automatic test_command_bytes();
        write_display_enable(1'b1);
        send_write(REG_CMD, 8'h01);
        send_write(REG_CMD, BYTE_FF);
        send_write(REG_CMD, CMD_SKIP1);
        send_write(REG_CMD, CMD_SKIP1);
        send_write(3'd0, BYTE_ZERO);
        send_write(3'd7, BYTE_FF);
    endtask

    // mode command then 1 is remapped, a second mode command completes one
    task automatic test_mode_remap();
        send_write(REG_DATA, MODE_CMD);
        send_write(REG_DATA, MODE_ONE);
        send_write(REG_DATA, MODE_CMD);
        send_write(REG_DATA, MODE_CMD);
    endtask

    // zero length word block, then a 0xff transfer through its phases
    task automatic test_word_transfer();
        send_write(REG_CMD, CMD_WORD);
        send_write(REG_CMD, CMD_SKIP2_B);
        send_write(REG_CMD, BYTE_ZERO);
        send_write(REG_CMD, 8'h20);
        send_write(REG_CMD, CMD_WORD);
        send_write(REG_CMD, BYTE_FF);
        send_write(REG_CMD, 8'h05);
        send_write(REG_CMD, 8'h12);
        send_write(REG_CMD, 8'h34);
        send_write(REG_DATA, 8'h41);
        send_write(REG_CMD, BYTE_ZERO);
        send_write(REG_CMD, BYTE_FF);
        send_write(REG_CMD, BYTE_ZERO);
        send_write(REG_CMD, 8'h07);
    endtask

    // frames, display runs, noise and full pauses under one idling mix
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_in, input logic enable);
        int unsigned roll;
        int          stop_at;
        write_display_enable(enable);
        send_idle_pct = idle_pct;
        stall_pct = stall_in;
        stop_at = items_driven + count;
        while (items_driven < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 55) send_command_frame();
            else if (roll < 80) send_display_run();
            else if (roll < 97) send_write(3'($urandom_range(7)), 8'($urandom_range(255)));
            else drain_results();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_valid = 1'b0;
        i_reg_index = 3'd0;
        i_write_byte = 8'd0;
        i_ready = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_writes_while_disabled();
        test_command_bytes();
        test_mode_remap();
        test_word_transfer();
        test_random_traffic(140, 0, 0, 1'b1);
        test_random_traffic(140, 63, 0, 1'b1);
        test_random_traffic(30, 20, 20, 1'b0);
        test_random_traffic(140, 0, 63, 1'b1);
        test_random_traffic(140, 20, 20, 1'b1);

        drain_results();
        repeat (10) @(negedge i_clk);
        if (expected_words.size() != 0)
            report_mismatch("result words never returned", 8'(expected_words.size()), 8'd0);

        $display("ran %0d register writes and checked %0d result words across four idling mixes",
                 items_driven, words_checked);
        $display("forwarded %0d display bytes, %0d mode completions, %0d command errors, %0d %s",
                 shown_bytes, mode_changes, cmd_errors, phase_words, "words in transfer phase");
        if (mismatches == 0) begin
            $display("PASS tube_r2_command_tracker");
        end else begin
            $display("FAIL tube_r2_command_tracker");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/tube_trk_pkg.sv
hdl/tube_r2_command_tracker.sv
tb/sv/testbench.sv
